[hw/rtl/qsde_pkg.sv]
// -----------------------------------------------------------------------------
// qsde_pkg
// Shared constants and types for the descending quicksort unit.
// -----------------------------------------------------------------------------
`default_nettype none
package qsde_pkg;
    localparam int MAX_ITEMS   = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(MAX_ITEMS);
    localparam int CNT_W       = IDX_W + 1;

    typedef logic [IDX_W-1:0]       t_idx;
    typedef logic [CNT_W-1:0]       t_cnt;
    typedef logic [VALUE_WIDTH-1:0] t_val;

    // Operations the controller issues to the datapath.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,      // write input value at count, count++
        OP_DROP,      // set dropped flag
        OP_INIT,      // clear stack, push full range if count >= 2
        OP_POP,       // read top of range stack, sp--
        OP_RDPIV,     // latch popped lo/hi, read store at lo
        OP_PIVSET,    // latch pivot, i=lo, j=hi
        OP_RDJ,       // read store at j
        OP_RDI,       // read store at i
        OP_SCANJ,     // use rdata as value at j
        OP_SCANI,     // use rdata as value at i
        OP_FINISH,    // write pivot at i, push subranges
        OP_EMITRD,    // read store at count-1-k
        OP_EMITNXT,   // k++
        OP_CLEAR      // clear count, flag, k, sp
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic full;       // count == MAX_ITEMS
        logic stack_empty;
        logic range_ok;   // lo < hi
        logic i_lt_j;
        logic scan_cont;  // scan condition holds on current data
        logic emit_last;  // k + 1 == count
    } t_status;
endpackage
`default_nettype wire

[hw/rtl/qsde_ram.sv]
// -----------------------------------------------------------------------------
// qsde_ram
// Generic single-port RAM with registered read data.
// -----------------------------------------------------------------------------
`default_nettype none
module qsde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Read-first port, read data registered.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

[hw/rtl/qsde_datapath.sv]
// -----------------------------------------------------------------------------
// qsde_datapath
// Value store, range stack, partition indices and pivot for the sorter.
// -----------------------------------------------------------------------------
`default_nettype none
module qsde_datapath (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire qsde_pkg::t_cmd            i_cmd,
    input  wire logic                      i_scan_dir,  // 0: scan j, 1: scan i
    input  wire qsde_pkg::t_val            i_value,
    output qsde_pkg::t_status              o_status,
    output qsde_pkg::t_val                 o_rdata,
    output logic                           o_dropped
);
    import qsde_pkg::*;

    t_cnt r_count, r_sp, r_k;
    t_idx r_lo, r_hi, r_i, r_j;
    t_val r_pivot;
    logic r_dropped;

    // Store port control.
    logic ram_we;
    t_idx ram_addr;
    t_val ram_wdata, ram_rdata;

    // Stack port control.
    logic stk_we;
    t_idx stk_addr;
    logic [2*IDX_W-1:0] stk_wdata, stk_rdata;

    logic [2*IDX_W-1:0] r_push2;
    logic r_push2_v;

    logic ge_piv, lt_piv;
    assign ge_piv = $signed(ram_rdata) >= $signed(r_pivot);
    assign lt_piv = $signed(ram_rdata) <  $signed(r_pivot);

    qsde_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_ITEMS)) u_store (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(ram_wdata), .o_rdata(ram_rdata)
    );

    qsde_ram #(.WIDTH(2*IDX_W), .DEPTH(MAX_ITEMS)) u_stack (
        .i_clk(i_clk), .i_we(stk_we), .i_addr(stk_addr),
        .i_wdata(stk_wdata), .o_rdata(stk_rdata)
    );

    // Address and write selection per operation.
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_lo;
        ram_wdata = ram_rdata;
        // The deferred right-hand push goes just below the updated pointer.
        stk_we    = r_push2_v;
        stk_addr  = r_push2_v ? t_idx'(r_sp - t_cnt'(1)) : r_sp[IDX_W-1:0];
        stk_wdata = r_push2;
        case (i_cmd.op)
            OP_LOAD: begin
                ram_we    = 1'b1;
                ram_addr  = r_count[IDX_W-1:0];
                ram_wdata = i_value;
            end
            OP_INIT: begin
                stk_we    = r_count >= t_cnt'(2);
                stk_addr  = '0;
                stk_wdata = {t_idx'(r_count - t_cnt'(1)), t_idx'(0)};
            end
            OP_POP: begin
                stk_addr = t_idx'(r_sp - t_cnt'(1));
            end
            OP_RDPIV: ram_addr = stk_rdata[IDX_W-1:0];
            OP_RDJ:   ram_addr = r_j;
            OP_RDI:   ram_addr = r_i;
            OP_SCANJ: begin
                // Value at j below pivot fills the hole at i.
                ram_addr = r_i;
                ram_we   = (r_i < r_j) && !ge_piv;
            end
            OP_SCANI: begin
                ram_addr = r_j;
                ram_we   = (r_i < r_j) && !lt_piv;
            end
            OP_FINISH: begin
                ram_we    = 1'b1;
                ram_addr  = r_i;
                ram_wdata = r_pivot;
                stk_we    = r_i > r_lo + t_idx'(1);
                stk_addr  = r_sp[IDX_W-1:0];
                stk_wdata = {t_idx'(r_i - t_idx'(1)), r_lo};
            end
            OP_EMITRD: ram_addr = t_idx'(r_count - t_cnt'(1) - r_k);
            default: ;
        endcase
    end

    // Index, counter and flag updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_sp      <= '0;
            r_k       <= '0;
            r_dropped <= 1'b0;
            r_push2_v <= 1'b0;
        end else begin
            // Deferred second push of a partition lands in the cycle after the finish.
            r_push2_v <= (i_cmd.op == OP_FINISH)
                         && (t_cnt'(r_i) + t_cnt'(1) < t_cnt'(r_hi));
            case (i_cmd.op)
                OP_LOAD: r_count <= r_count + t_cnt'(1);
                OP_DROP: r_dropped <= 1'b1;
                OP_INIT: r_sp <= (r_count >= t_cnt'(2)) ? t_cnt'(1) : t_cnt'(0);
                OP_POP: r_sp <= r_sp - t_cnt'(1);
                OP_PIVSET: begin
                    r_pivot <= ram_rdata;
                    r_i     <= r_lo;
                    r_j     <= r_hi;
                end
                OP_SCANJ: begin
                    if (r_i < r_j) begin
                        if (ge_piv) begin
                            r_j <= r_j - t_idx'(1);
                        end else begin
                            r_i <= r_i + t_idx'(1);
                        end
                    end
                end
                OP_SCANI: begin
                    if (r_i < r_j) begin
                        if (lt_piv) begin
                            r_i <= r_i + t_idx'(1);
                        end else begin
                            r_j <= r_j - t_idx'(1);
                        end
                    end
                end
                OP_FINISH: begin
                    r_sp <= r_sp + t_cnt'(r_i > r_lo + t_idx'(1))
                                 + t_cnt'(t_cnt'(r_i) + t_cnt'(1) < t_cnt'(r_hi));
                end
                OP_EMITNXT: r_k <= r_k + t_cnt'(1);
                OP_CLEAR: begin
                    r_count   <= '0;
                    r_dropped <= 1'b0;
                    r_k       <= '0;
                    r_sp      <= '0;
                end
                default: ;
            endcase
        end
    end

    // Popped range and second push payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_RDPIV) begin
            r_lo <= stk_rdata[IDX_W-1:0];
            r_hi <= stk_rdata[2*IDX_W-1:IDX_W];
        end
        if (i_cmd.op == OP_FINISH) begin
            r_push2 <= {r_hi, t_idx'(r_i + t_idx'(1))};
        end
    end

    always_comb begin
        o_status.full        = r_count == t_cnt'(MAX_ITEMS);
        o_status.stack_empty = r_sp == '0;
        o_status.range_ok    = stk_rdata[IDX_W-1:0] < stk_rdata[2*IDX_W-1:IDX_W];
        o_status.i_lt_j      = r_i < r_j;
        o_status.scan_cont   = i_scan_dir ? lt_piv : ge_piv;
        o_status.emit_last   = (r_k + t_cnt'(1)) == r_count;
    end

    assign o_rdata   = ram_rdata;
    assign o_dropped = r_dropped;
endmodule
`default_nettype wire

[hw/rtl/qsde_ctrl.sv]
// -----------------------------------------------------------------------------
// qsde_ctrl
// Sequencer: load, partition loop over the range stack, and emit.
// -----------------------------------------------------------------------------
`default_nettype none
module qsde_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_last,
    output logic                    o_in_ready,
    output logic                    o_out_load,
    input  wire logic               i_out_free,
    output qsde_pkg::t_cmd          o_cmd,
    output logic                    o_scan_dir,
    input  wire qsde_pkg::t_status  i_status
);
    import qsde_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD, S_INIT, S_POP, S_POPW, S_PIV, S_RDJ, S_SCANJ, S_RDI, S_SCANI,
        S_FIN, S_PUSH2, S_ERD, S_EOUT
    } t_state;

    t_state r_state;
    logic   r_dir;

    assign o_in_ready = r_state == S_LOAD;
    assign o_scan_dir = r_dir;

    // Command decode per state.
    always_comb begin
        o_cmd.op   = OP_NONE;
        o_out_load = 1'b0;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.op = i_status.full ? OP_DROP : OP_LOAD;
                end
            end
            S_INIT:  o_cmd.op = OP_INIT;
            S_POP:   o_cmd.op = OP_POP;
            S_POPW:  o_cmd.op = OP_RDPIV;
            S_PIV:   o_cmd.op = OP_PIVSET;
            S_RDJ:   o_cmd.op = OP_RDJ;
            S_SCANJ: o_cmd.op = OP_SCANJ;
            S_RDI:   o_cmd.op = OP_RDI;
            S_SCANI: o_cmd.op = OP_SCANI;
            S_FIN:   o_cmd.op = OP_FINISH;
            S_ERD:   o_cmd.op = OP_EMITRD;
            S_EOUT: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    o_cmd.op   = i_status.emit_last ? OP_CLEAR : OP_EMITNXT;
                end else begin
                    // Keep reading the same entry while the output is stalled.
                    o_cmd.op   = OP_EMITRD;
                end
            end
            default: ;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_dir   <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD:  if (i_in_valid && i_in_last) r_state <= S_INIT;
                S_INIT:  r_state <= S_POP;
                S_POP:   r_state <= i_status.stack_empty ? S_ERD : S_POPW;
                S_POPW:  r_state <= i_status.range_ok ? S_PIV : S_POP;
                S_PIV: begin
                    r_state <= S_RDJ;
                    r_dir   <= 1'b0;
                end
                S_RDJ: r_state <= i_status.i_lt_j ? S_SCANJ : S_FIN;
                S_SCANJ: begin
                    if (!i_status.i_lt_j) begin
                        r_state <= S_FIN;
                    end else if (i_status.scan_cont) begin
                        r_state <= S_RDJ;
                    end else begin
                        r_state <= S_RDI;
                        r_dir   <= 1'b1;
                    end
                end
                S_RDI: r_state <= i_status.i_lt_j ? S_SCANI : S_FIN;
                S_SCANI: begin
                    if (!i_status.i_lt_j) begin
                        r_state <= S_FIN;
                    end else if (i_status.scan_cont) begin
                        r_state <= S_RDI;
                    end else begin
                        r_state <= S_RDJ;
                        r_dir   <= 1'b0;
                    end
                end
                S_FIN:   r_state <= S_PUSH2;
                S_PUSH2: r_state <= S_POP;
                S_ERD:   r_state <= S_EOUT;
                S_EOUT: begin
                    if (i_out_free) begin
                        r_state <= i_status.emit_last ? S_LOAD : S_ERD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // Input is taken only while loading.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == S_LOAD)
        else $error("ready outside load");
    // An output load always follows a store read.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_load |-> $past(r_state) == S_ERD || $past(r_state) == S_EOUT)
        else $error("output load without read");
    // Finishing a partition always leads to the second push cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN |=> r_state == S_PUSH2)
        else $error("finish not followed by push");
endmodule
`default_nettype wire

[hw/rtl/quicksort_descending_emit_unit.sv]
// -----------------------------------------------------------------------------
// quicksort_descending_emit_unit
// Collects signed values, sorts them by quicksort, emits them largest first.
// -----------------------------------------------------------------------------
// Loading takes one input transfer per cycle until the last flag arrives.
// Sorting then pops ranges off the range stack and partitions each through the
// single store port, comparing one stored value against the pivot at a time.
// Emitting reads each result through the registered store read into the output.
// Synchronous active-low reset clears counts, stack pointer and the flag.
`default_nettype none
module quicksort_descending_emit_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] value
    input  wire logic        s_axis_tlast,   // last_in
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] sorted_value
    output logic             m_axis_tlast,   // last_out
    output logic             m_axis_tuser    // overflow
);
    import qsde_pkg::*;

    t_cmd    cmd;
    t_status status;
    t_val    rdata;
    logic    dropped, scan_dir, out_load, out_free;

    assign out_free = !m_axis_tvalid || m_axis_tready;

    qsde_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_last(s_axis_tlast),
        .o_in_ready(s_axis_tready), .o_out_load(out_load), .i_out_free(out_free),
        .o_cmd(cmd), .o_scan_dir(scan_dir), .i_status(status)
    );

    qsde_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_scan_dir(scan_dir),
        .i_value(s_axis_tdata), .o_status(status), .o_rdata(rdata),
        .o_dropped(dropped)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (out_load) begin
            m_axis_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            m_axis_tdata <= rdata;
            m_axis_tlast <= status.emit_last;
            m_axis_tuser <= dropped;
        end
    end
endmodule
`default_nettype wire
